/* hw/rtl/ncgc_pkg.sv */
// Shared types and constants for the nearest-centroid gate check block.
// Holds the transfer payload structs, command and register codes, shift amounts.
// No dependencies.
`default_nettype none

package ncgc_pkg;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         table_index;
    logic [3:0]         claimed_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  nearest_index;
    logic [31:0] claimed_distance;
  } out_item_t;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_GATE   = 1'b1;

  localparam logic [4:0]  ACTIVE_RESET = 5'd16;
  localparam logic [31:0] DIST_NONE    = 32'hFFFF_FFFF;

  localparam int DIFF_W     = 33;
  localparam int DIST_SHIFT = 8;
  localparam int STEP_SHIFT = 3;
  localparam int DX_W       = DIFF_W - DIST_SHIFT;

endpackage

`default_nettype wire

/* hw/rtl/nearest_centroid_gate_check_core.sv */
// Nearest-centroid gate check: holds a reference table and a running point,
// answers membership claims. Depends on ncgc_pkg.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries commands. Command 0 writes
//   one table entry, command 1 moves the running point one eighth of the way
//   toward the sample; both finish in the cycle of their transfer and give no
//   result. Command 3 is dropped. Command 2 starts a search over the active
//   entries and returns one result on out_valid/out_ready/out_data.
//   Command 2 keeps in_ready low from its transfer to its result. Its search
//   runs through the distance pipeline (table read, difference, square,
//   accumulate), which takes one table entry per cycle plus the claimed entry.
//   The result sits in an output register: commands 0 and 1 keep flowing
//   while it waits, and a following check holds in its final state until the
//   register is free, so a stalled receiver only delays the next check.
//   Configuration goes through the APB port: active_count at 0x0, gate_squared
//   at 0x4. pready is always high. Write registers only while the block idles.
//   Reset (synchronous, rst high) clears the running point to zero, sets
//   active_count to 16 and gate_squared to all ones, and empties the output.
//   Table contents are undefined until written.
`default_nettype none

module nearest_centroid_gate_check_core
  import ncgc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // configuration
  logic [4:0]  active_count;
  logic [31:0] gate_squared;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ACTIVE_RESET;
      gate_squared <= DIST_NONE;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACTIVE: active_count <= pwdata[4:0];
        REG_GATE:   gate_squared <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACTIVE: prdata = {27'd0, active_count};
      REG_GATE:   prdata = gate_squared;
      default:    prdata = '0;
    endcase
  end

  // sequencer and control
  logic [1:0]       state;
  logic [CNT_W-1:0] iss;
  logic [CNT_W-1:0] m;
  logic             claim_done;
  logic [3:0]       cidx;
  logic             claim_ok;
  logic             in_fire;
  logic             tidx_ok;
  logic [7:0]       ac_ext;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign tidx_ok  = 8'(in_data.table_index) < 8'(MAX_ENTRIES);
  assign claim_ok = 8'(cidx) < 8'(MAX_ENTRIES);
  assign ac_ext   = 8'(active_count);
  assign m        = (ac_ext > 8'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(ac_ext);

  // running point
  logic [31:0] running_x;
  logic [31:0] running_y;
  logic [DIFF_W-1:0] ux_diff;
  logic [DIFF_W-1:0] uy_diff;
  logic [31:0] running_x_next;
  logic [31:0] running_y_next;

  always_comb begin
    ux_diff = {in_data.point_x[31], in_data.point_x} - {running_x[31], running_x};
    uy_diff = {in_data.point_y[31], in_data.point_y} - {running_y[31], running_y};
    running_x_next = running_x +
      {{(STEP_SHIFT-1){ux_diff[DIFF_W-1]}}, ux_diff[DIFF_W-1:STEP_SHIFT]};
    running_y_next = running_y +
      {{(STEP_SHIFT-1){uy_diff[DIFF_W-1]}}, uy_diff[DIFF_W-1:STEP_SHIFT]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_x <= '0;
      running_y <= '0;
    end else if (in_fire && in_data.command == CMD_UPDATE) begin
      running_x <= running_x_next;
      running_y <= running_y_next;
    end
  end

  // reference table: x in the upper half, y in the lower half
  logic [63:0]   mem [MAX_ENTRIES];
  logic [63:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          issue_v;
  logic          issue_claim;

  always_ff @(posedge clk) begin
    if (in_fire && in_data.command == CMD_WRITE && tidx_ok) begin
      mem[AW'(in_data.table_index)] <= {in_data.point_x, in_data.point_y};
    end
  end

  always_comb begin
    issue_v     = 1'b0;
    issue_claim = 1'b0;
    rd_addr     = '0;
    if (state == ST_RUN) begin
      if (iss < m) begin
        issue_v = 1'b1;
        rd_addr = iss[AW-1:0];
      end else if (!claim_done && claim_ok) begin
        issue_v     = 1'b1;
        issue_claim = 1'b1;
        rd_addr     = AW'(cidx);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // distance pipeline: read, difference, square, accumulate
  logic          v0, v1, v2;
  logic          c0, c1, c2;
  logic [AW-1:0] idx0, idx1, idx2;
  logic [DIFF_W-1:0] dx_full;
  logic [DIFF_W-1:0] dy_full;
  logic signed [DX_W-1:0] dx, dy;
  logic signed [2*DX_W-1:0] prod_x, prod_y;
  logic [31:0] sq_x, sq_y;
  logic [31:0] dist_sum;

  assign dx_full  = {running_x[31], running_x} - {rd_data[63], rd_data[63:32]};
  assign dy_full  = {running_y[31], running_y} - {rd_data[31], rd_data[31:0]};
  assign prod_x   = dx * dx;
  assign prod_y   = dy * dy;
  assign dist_sum = sq_x + sq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= issue_v;
      v1 <= v0;
      v2 <= v1;
    end
    c0   <= issue_claim;
    idx0 <= rd_addr;
    c1   <= c0;
    idx1 <= idx0;
    dx   <= dx_full[DIFF_W-1:DIST_SHIFT];
    dy   <= dy_full[DIFF_W-1:DIST_SHIFT];
    c2   <= c1;
    idx2 <= idx1;
    sq_x <= prod_x[31:0];
    sq_y <= prod_y[31:0];
  end

  // search result
  logic [31:0]   best;
  logic [AW-1:0] besti;
  logic [31:0]   di;
  logic          verdict;
  logic          out_free;

  assign verdict  = claim_ok && (8'(besti) == 8'(cidx)) && (di <= gate_squared);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (in_fire && in_data.command == CMD_CHECK) begin
      best  <= DIST_NONE;
      besti <= '0;
      di    <= DIST_NONE;
      cidx  <= in_data.claimed_index;
    end else if (v2) begin
      if (c2) begin
        di <= dist_sum;
      end else if (dist_sum < best) begin
        best  <= dist_sum;
        besti <= idx2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      iss        <= '0;
      claim_done <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && in_data.command == CMD_CHECK) begin
            state      <= ST_RUN;
            iss        <= '0;
            claim_done <= 1'b0;
          end
        end
        ST_RUN: begin
          if (iss < m) begin
            iss <= iss + 1'b1;
          end else if (!claim_done) begin
            claim_done <= 1'b1;
          end else if (!v0 && !v1 && !v2) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_data.accepted         <= verdict;
      out_data.nearest_index    <= 4'(besti);
      out_data.claimed_distance <= di;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ncgc_checker.sv */
// Port-level checks for the nearest-centroid gate check block, bound to the top level.
// Depends on ncgc_pkg and nearest_centroid_gate_check_core.
`default_nettype none

module ncgc_checker
  import ncgc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.command == CMD_CHECK |=> !in_ready)
    else $error("input taken during a search");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind nearest_centroid_gate_check_core ncgc_checker u_ncgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/ncgc_verdict_checker.sv */
// Checker for the nearest-centroid gate check block: watches the APB port and both
// valid/ready channels, predicts each check verdict and compares it field by field.
// Depends on ncgc_pkg.
`timescale 1ns / 1ps

module ncgc_verdict_checker
  import ncgc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          pending,
  output int          mismatches
);

  logic [31:0] anchor_x [MAX_ENTRIES];
  logic [31:0] anchor_y [MAX_ENTRIES];
  logic [31:0] track_x;
  logic [31:0] track_y;
  logic [4:0]  active_cfg;
  logic [31:0] gate_cfg;
  out_item_t   verdicts_due [$];
  out_item_t   want;
  int          fail_total;

  initial begin
    pending    = 0;
    mismatches = 0;
    fail_total = 0;
  end

  // floor-shifted differences, squared, wrapped to 32 bits
  function automatic logic [31:0] sq_dist(input logic [31:0] ax, input logic [31:0] ay,
                                          input logic [31:0] bx, input logic [31:0] by);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    longint sx;
    longint sy;
    dx = $signed({ax[31], ax}) - $signed({bx[31], bx});
    dy = $signed({ay[31], ay}) - $signed({by[31], by});
    sx = dx >>> DIST_SHIFT;
    sy = dy >>> DIST_SHIFT;
    return 32'(sx * sx + sy * sy);
  endfunction

  function automatic logic [31:0] ema_eighth(input logic [31:0] cur, input logic [31:0] smp);
    logic signed [32:0] d;
    d = $signed({smp[31], smp}) - $signed({cur[31], cur});
    d = d >>> STEP_SHIFT;
    return cur + d[31:0];
  endfunction

  function automatic out_item_t predict_verdict(input logic [3:0] claim);
    out_item_t   v;
    logic [31:0] best;
    logic [31:0] d;
    int          lim;
    lim = (active_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(active_cfg);
    best = DIST_NONE;
    v.accepted = 1'b0;
    v.nearest_index = '0;
    v.claimed_distance = DIST_NONE;
    for (int k = 0; k < lim; k++) begin
      d = sq_dist(track_x, track_y, anchor_x[k], anchor_y[k]);
      // strict compare keeps the lower index on ties
      if (d < best) begin
        best = d;
        v.nearest_index = 4'(k);
      end
    end
    if (claim < MAX_ENTRIES) begin
      v.claimed_distance = sq_dist(track_x, track_y, anchor_x[claim], anchor_y[claim]);
      v.accepted = (v.nearest_index == claim) && (v.claimed_distance <= gate_cfg);
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      track_x    = '0;
      track_y    = '0;
      active_cfg = ACTIVE_RESET;
      gate_cfg   = DIST_NONE;
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_GATE) gate_cfg = pwdata;
        else active_cfg = pwdata[4:0];
      end
      if (in_valid && in_ready) begin
        case (in_data.command)
          CMD_WRITE: begin
            if (in_data.table_index < MAX_ENTRIES) begin
              anchor_x[in_data.table_index] = in_data.point_x;
              anchor_y[in_data.table_index] = in_data.point_y;
            end
          end
          CMD_UPDATE: begin
            track_x = ema_eighth(track_x, in_data.point_x);
            track_y = ema_eighth(track_y, in_data.point_y);
          end
          CMD_CHECK: verdicts_due.push_back(predict_verdict(in_data.claimed_index));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected result: acc=%0d near=%0d dist=%h",
                     out_data.accepted, out_data.nearest_index, out_data.claimed_distance);
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.accepted !== want.accepted ||
              out_data.nearest_index !== want.nearest_index ||
              out_data.claimed_distance !== want.claimed_distance) begin
            fail_total++;
            if (fail_total <= 10)
              $display("result mismatch: exp acc=%0d near=%0d dist=%h, got acc=%0d near=%0d dist=%h",
                       want.accepted, want.nearest_index, want.claimed_distance,
                       out_data.accepted, out_data.nearest_index, out_data.claimed_distance);
          end
        end
      end
    end
    pending    <= verdicts_due.size();
    mismatches <= fail_total;
  end

endmodule

/* tb/nearest_centroid_gate_check_core_tb.sv */
// Top of the nearest-centroid gate check testbench: clock, reset, APB setup,
// bursty command stimulus and a stalling receiver; checking is done in ncgc_verdict_checker.
// Depends on ncgc_pkg, nearest_centroid_gate_check_core and ncgc_verdict_checker.
`timescale 1ns / 1ps

module nearest_centroid_gate_check_core_tb;
  import ncgc_pkg::*;

  localparam int N_ENT  = 16;
  localparam int LIMIT  = 400_000;
  localparam int SETTLE = 30;
  localparam int PHASE_ITEMS = 115;
  localparam logic [2:0] ADDR_ACTIVE = {REG_ACTIVE, 2'b00};
  localparam logic [2:0] ADDR_GATE   = {REG_GATE, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int          pending;
  int          mismatches;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          rx_hold_req = 1'b0;
  logic [31:0] placed_x [N_ENT];
  logic [31:0] placed_y [N_ENT];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nearest_centroid_gate_check_core #(.MAX_ENTRIES(N_ENT)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ncgc_verdict_checker #(.MAX_ENTRIES(N_ENT)) verdict_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .pending(pending), .mismatches(mismatches)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("nearest_centroid_gate_check_core_tb failed");
      $finish;
    end
  end

  // receiver: random stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] cmd, input logic [3:0] tidx,
                                  input logic [3:0] cidx, input logic [31:0] x,
                                  input logic [31:0] y);
    in_item_t it;
    it.command = cmd;
    it.table_index = tidx;
    it.claimed_index = cidx;
    it.point_x = x;
    it.point_y = y;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] near(input logic [31:0] c);
    return c + 32'($urandom_range(0, 32'h8000)) - 32'h4000;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic place(input logic [3:0] idx, input logic [31:0] x, input logic [31:0] y);
    placed_x[idx] = x;
    placed_y[idx] = y;
    send_item(mk(CMD_WRITE, idx, 4'($urandom()), x, y));
  endtask

  task automatic step_toward(input logic [31:0] x, input logic [31:0] y);
    send_item(mk(CMD_UPDATE, 4'($urandom()), 4'($urandom()), x, y));
  endtask

  task automatic claim(input logic [3:0] idx);
    send_item(mk(CMD_CHECK, 4'($urandom()), idx, $urandom(), $urandom()));
  endtask

  // hold the sender until every result is in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [4:0] active, input logic [31:0] gate);
    apb_write(ADDR_ACTIVE, {27'd0, active});
    apb_write(ADDR_GATE, gate);
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int r;
    int steps;
    logic [3:0] k;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        place(4'($urandom()), rand_coord(), rand_coord());
        sent++;
      end else if (r < 67) begin
        // pull the running point toward one entry, then claim it (mostly)
        k = 4'($urandom());
        steps = $urandom_range(1, 10);
        repeat (steps) step_toward(near(placed_x[k]), near(placed_y[k]));
        claim(($urandom_range(0, 9) < 7) ? k : 4'($urandom()));
        sent += steps + 1;
      end else if (r < 80) begin
        step_toward(rand_coord(), rand_coord());
        sent++;
      end else if (r < 95) begin
        claim(4'($urandom()));
        sent++;
      end else begin
        send_item(mk(2'd3, 4'($urandom()), 4'($urandom()), $urandom(), $urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table first: extremes, a duplicate of the origin, random points
    for (int i = 0; i < N_ENT; i++) begin
      case (i)
        0: place(4'(i), 32'h7FFF_FFFF, 32'h8000_0000);
        1: place(4'(i), 32'h8000_0000, 32'h7FFF_FFFF);
        2, 7: place(4'(i), 32'h0000_0000, 32'h0000_0000);
        3: place(4'(i), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: place(4'(i), rand_coord(), rand_coord());
      endcase
    end
    claim(4'd7);
    claim(4'd2);
    send_item(mk(2'd3, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    step_toward(32'h7FFF_FFFF, 32'h8000_0000);
    step_toward(32'h8000_0000, 32'h7FFF_FFFF);
    claim(4'd15);
    claim(4'd0);
    drain();

    configure(5'd16, DIST_NONE);
    rx_hold_req <= 1'b1;
    run_phase(PHASE_ITEMS);
    drain();
    configure(5'd1, 32'd0);
    run_phase(PHASE_ITEMS);
    drain();
    configure(5'd0, $urandom());
    run_phase(PHASE_ITEMS);
    drain();
    configure(5'd31, 32'h0400_0000);
    run_phase(PHASE_ITEMS);
    drain();
    configure(5'd17, $urandom());
    run_phase(PHASE_ITEMS);
    drain();
    configure(5'($urandom_range(2, 15)), $urandom_range(0, 32'h1000_0000));
    run_phase(PHASE_ITEMS);
    drain();
    configure(5'd16, 32'h0400_0000);
    run_phase(PHASE_ITEMS);
    drain();
    configure(5'd16, DIST_NONE);
    run_phase(PHASE_ITEMS);
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("nearest_centroid_gate_check_core_tb passed");
    end else begin
      $display("nearest_centroid_gate_check_core_tb failed");
    end
    $finish;
  end

endmodule
